// ===== src/lcabl_pkg.sv =====
package lcabl_pkg;

  // Tree size and lifting depth
  localparam int NODES   = 1024;
  localparam int LEVELS  = 10;

  localparam int FIELD_W = 10;
  localparam int DEPTH_W = 10;
  localparam int NODE_W  = $clog2(NODES);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENTRIES = NODES * LEVELS;
  localparam int ADDR_W  = $clog2(ENTRIES);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  // Access request to the ancestor and depth tables
  typedef struct packed {
    logic   anc_we;
    addr_t  anc_addr;
    node_t  anc_wdata;
    logic   dep_we;
    node_t  dep_addr;
    depth_t dep_wdata;
  } tbl_req_t;

  // Out-of-range node index maps to the sentinel
  function automatic node_t to_node(input logic [FIELD_W-1:0] v);
    node_t n;
    if (int'(v) < NODES) begin
      n = node_t'(v);
    end else begin
      n = '0;
    end
    return n;
  endfunction

  // Flat address of entry (node, level) of the ancestor table
  function automatic addr_t anc_addr(input node_t n, input lvl_t l);
    addr_t a;
    a = addr_t'(addr_t'(n) * addr_t'(LEVELS)) + addr_t'(l);
    return a;
  endfunction

endpackage

// ===== src/lcabl_tables.sv =====
module lcabl_tables (
  input  logic                clk,
  input  logic                rst,
  input  lcabl_pkg::tbl_req_t req,
  output lcabl_pkg::node_t    anc_rdata,
  output lcabl_pkg::depth_t   dep_rdata,
  output logic                busy
);

  lcabl_pkg::node_t  anc_mem [lcabl_pkg::ENTRIES];
  lcabl_pkg::depth_t dep_mem [lcabl_pkg::NODES];

  lcabl_pkg::addr_t clr_addr;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == lcabl_pkg::addr_t'(lcabl_pkg::ENTRIES - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Ancestor table: one port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      anc_mem[clr_addr] <= '0;
    end else if (req.anc_we) begin
      anc_mem[req.anc_addr] <= req.anc_wdata;
    end
    anc_rdata <= anc_mem[req.anc_addr];
  end

  // Depth table: one port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      if (int'(clr_addr) < lcabl_pkg::NODES) begin
        dep_mem[lcabl_pkg::node_t'(clr_addr)] <= '0;
      end
    end else if (req.dep_we) begin
      dep_mem[req.dep_addr] <= req.dep_wdata;
    end
    dep_rdata <= dep_mem[req.dep_addr];
  end

endmodule

// ===== src/lca_binary_lifting.sv =====
// Lowest common ancestor by binary lifting.
// Input channel (in_valid/in_ready) carries cmd, node_a, node_b. cmd insert
// places node_a under parent node_b (0 makes it a root); parents go in before
// their children. cmd query asks for the common ancestor of node_a and node_b.
// Output channel (out_valid/out_ready) carries one ancestor item per query;
// inserts give no item.
// One item is worked at a time over a single table port and one compare /
// subtract unit; in_ready is low while an item is in flight:
//   insert: a parent depth read, the depth and level-0 row write, then one
//           chained read and write per further level
//   query:  two depth reads and the compare, up to LEVELS lift reads, a read
//           of both rows and a compare per level of the climb, then the final parent read and its capture.
// An insert of node 0 finishes in its accept cycle.
// After reset both tables are swept to zero, one entry a cycle, over all
// NODES*LEVELS = 10240 entries; in_ready stays low meanwhile.
// The result sits in an output register; the next item is taken while it
// waits. A query that finishes while out_valid is still held waits for
// out_ready before loading its result.
module lca_binary_lifting (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [lcabl_pkg::FIELD_W-1:0]       node_a,
  input  logic [lcabl_pkg::FIELD_W-1:0]       node_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lcabl_pkg::FIELD_W-1:0]       ancestor
);

  typedef enum logic [3:0] {
    S_IDLE, S_I_DEP, S_I_DEPW, S_I_RD, S_I_WR,
    S_Q_DA, S_Q_DB, S_Q_CMP, S_Q_LIFT, S_Q_LIFTW, S_Q_EQ,
    S_Q_CA, S_Q_CB, S_Q_CC, S_Q_FIN, S_Q_DONE
  } state_t;

  state_t                       state;
  lcabl_pkg::node_t             a;
  lcabl_pkg::node_t             b;
  lcabl_pkg::node_t             ta;
  lcabl_pkg::depth_t            da;
  lcabl_pkg::depth_t            diff;
  lcabl_pkg::lvl_t              lvl;
  logic                         fin_pending;

  lcabl_pkg::tbl_req_t          req;
  lcabl_pkg::node_t             anc_rdata;
  lcabl_pkg::depth_t            dep_rdata;
  logic                         busy;

  logic [lcabl_pkg::LEVELS-1:0] kbits;
  lcabl_pkg::lvl_t              lvl_prev;
  logic                         lvl_last;
  lcabl_pkg::node_t             in_a;
  lcabl_pkg::depth_t            dep_new;
  logic                         out_load;

  lcabl_tables u_tables (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .anc_rdata (anc_rdata),
    .dep_rdata (dep_rdata),
    .busy      (busy)
  );

  assign in_ready = (state == S_IDLE) && !busy;
  assign in_a     = lcabl_pkg::to_node(node_a);
  assign kbits    = lcabl_pkg::LEVELS'(diff);
  assign lvl_prev = lvl - 1'b1;
  assign lvl_last = (lvl == lcabl_pkg::lvl_t'(lcabl_pkg::LEVELS - 1));
  // result goes into the output register once the slot is free
  assign out_load = (state == S_Q_DONE) && !fin_pending && (!out_valid || out_ready);

  // Depth of a new node from its parent, saturating
  always_comb begin
    if (b == '0) begin
      dep_new = '0;
    end else if (dep_rdata >= lcabl_pkg::DEPTH_MAX) begin
      dep_new = lcabl_pkg::DEPTH_MAX;
    end else begin
      dep_new = dep_rdata + 1'b1;
    end
  end

  // Table requests per state
  always_comb begin
    req = '0;
    unique case (state)
      S_I_DEP: begin
        req.dep_addr = b;
      end
      S_I_DEPW: begin
        req.dep_we    = 1'b1;
        req.dep_addr  = a;
        req.dep_wdata = dep_new;
        req.anc_we    = 1'b1;
        req.anc_addr  = lcabl_pkg::anc_addr(a, '0);
        req.anc_wdata = b;
      end
      S_I_RD: begin
        req.anc_addr = lcabl_pkg::anc_addr(b, lvl_prev);
      end
      S_I_WR: begin
        req.anc_we    = 1'b1;
        req.anc_addr  = lcabl_pkg::anc_addr(a, lvl);
        req.anc_wdata = anc_rdata;
      end
      S_Q_DA: begin
        req.dep_addr = a;
      end
      S_Q_DB: begin
        req.dep_addr = b;
      end
      S_Q_LIFT, S_Q_CB: begin
        req.anc_addr = lcabl_pkg::anc_addr(b, lvl);
      end
      S_Q_CA: begin
        req.anc_addr = lcabl_pkg::anc_addr(a, lvl);
      end
      S_Q_FIN: begin
        req.anc_addr = lcabl_pkg::anc_addr(a, '0);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      fin_pending <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            a <= in_a;
            b <= lcabl_pkg::to_node(node_b);
            if (cmd == lcabl_pkg::CMD_QUERY) begin
              state <= S_Q_DA;
            end else if (in_a != '0) begin
              state <= S_I_DEP;
            end
          end
        end
        S_I_DEP: begin
          state <= S_I_DEPW;
        end
        S_I_DEPW: begin
          if (lcabl_pkg::LEVELS == 1) begin
            state <= S_IDLE;
          end else begin
            lvl   <= lcabl_pkg::lvl_t'(1);
            state <= S_I_RD;
          end
        end
        S_I_RD: begin
          state <= S_I_WR;
        end
        S_I_WR: begin
          b <= anc_rdata;
          if (lvl_last) begin
            state <= S_IDLE;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_I_RD;
          end
        end
        S_Q_DA: begin
          state <= S_Q_DB;
        end
        S_Q_DB: begin
          da    <= dep_rdata;
          state <= S_Q_CMP;
        end
        S_Q_CMP: begin
          // b becomes the deeper node
          if (da > dep_rdata) begin
            a    <= b;
            b    <= a;
            diff <= da - dep_rdata;
          end else begin
            diff <= dep_rdata - da;
          end
          lvl   <= '0;
          state <= S_Q_LIFT;
        end
        S_Q_LIFT: begin
          if (kbits[lvl]) begin
            state <= S_Q_LIFTW;
          end else if (lvl_last) begin
            state <= S_Q_EQ;
          end else begin
            lvl <= lvl + 1'b1;
          end
        end
        S_Q_LIFTW: begin
          b <= anc_rdata;
          if (lvl_last) begin
            state <= S_Q_EQ;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_Q_LIFT;
          end
        end
        S_Q_EQ: begin
          if (a == b) begin
            state <= S_Q_DONE;
          end else begin
            lvl   <= lcabl_pkg::lvl_t'(lcabl_pkg::LEVELS - 1);
            state <= S_Q_CA;
          end
        end
        S_Q_CA: begin
          state <= S_Q_CB;
        end
        S_Q_CB: begin
          ta    <= anc_rdata;
          state <= S_Q_CC;
        end
        S_Q_CC: begin
          if (ta != anc_rdata) begin
            a <= ta;
            b <= anc_rdata;
          end
          if (lvl == '0) begin
            state <= S_Q_FIN;
          end else begin
            lvl   <= lvl_prev;
            state <= S_Q_CA;
          end
        end
        S_Q_FIN: begin
          fin_pending <= 1'b1;
          state       <= S_Q_DONE;
        end
        S_Q_DONE: begin
          // capture the parent read once, then wait for the output slot
          if (fin_pending) begin
            a           <= anc_rdata;
            fin_pending <= 1'b0;
          end else if (out_load) begin
            ancestor <= lcabl_pkg::FIELD_W'(a);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  typedef logic [lcabl_pkg::FIELD_W-1:0] field_t;
  typedef lcabl_pkg::node_t  node_t;
  typedef lcabl_pkg::depth_t depth_t;

  localparam int FIELD_MAX    = (1 << lcabl_pkg::FIELD_W) - 1;
  localparam int NODES        = lcabl_pkg::NODES;
  localparam int LEVELS       = lcabl_pkg::LEVELS;
  localparam int RANDOM_ITEMS = 450;
  localparam int SAT_INSERTS  = 1030;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int MAX_REPORTS  = 10;

  // One directed item; want is used only where fixed is set
  typedef struct packed {
    logic   cmd;
    field_t a;
    field_t b;
    bit     fixed;
    field_t want;
  } step_t;

  localparam step_t DIRECTED [24] = '{
    '{lcabl_pkg::CMD_QUERY,  0,    0,    1'b1, 0},     // empty tables give the sentinel
    '{lcabl_pkg::CMD_QUERY,  1023, 1023, 1'b1, 1023},  // same node twice
    '{lcabl_pkg::CMD_QUERY,  1,    1023, 1'b1, 0},     // nodes never inserted
    '{lcabl_pkg::CMD_INSERT, 0,    5,    1'b0, 0},     // insert of node zero is dropped
    '{lcabl_pkg::CMD_QUERY,  0,    5,    1'b1, 0},
    '{lcabl_pkg::CMD_INSERT, 1,    0,    1'b0, 0},     // root
    '{lcabl_pkg::CMD_INSERT, 2,    1,    1'b0, 0},
    '{lcabl_pkg::CMD_INSERT, 3,    1,    1'b0, 0},
    '{lcabl_pkg::CMD_INSERT, 4,    2,    1'b0, 0},
    '{lcabl_pkg::CMD_INSERT, 1023, 4,    1'b0, 0},
    '{lcabl_pkg::CMD_QUERY,  4,    3,    1'b1, 1},
    '{lcabl_pkg::CMD_QUERY,  1023, 2,    1'b1, 2},     // one is ancestor of the other
    '{lcabl_pkg::CMD_QUERY,  2,    1023, 1'b1, 2},
    '{lcabl_pkg::CMD_INSERT, 700,  600,  1'b0, 0},     // parent never inserted
    '{lcabl_pkg::CMD_QUERY,  700,  600,  1'b1, 600},
    '{lcabl_pkg::CMD_QUERY,  700,  1,    1'b1, 0},     // separate trees
    '{lcabl_pkg::CMD_INSERT, 2,    3,    1'b0, 0},     // re-insert, children keep old rows
    '{lcabl_pkg::CMD_QUERY,  4,    3,    1'b0, 0},
    '{lcabl_pkg::CMD_INSERT, 5,    5,    1'b0, 0},     // node is its own parent
    '{lcabl_pkg::CMD_QUERY,  5,    5,    1'b1, 5},
    '{lcabl_pkg::CMD_QUERY,  1023, 1023, 1'b1, 1023},
    '{lcabl_pkg::CMD_INSERT, 1022, 1023, 1'b0, 0},
    '{lcabl_pkg::CMD_QUERY,  1022, 1,    1'b0, 0},
    '{lcabl_pkg::CMD_QUERY,  1022, 4,    1'b1, 4}
  };

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  logic   cmd;
  field_t node_a;
  field_t node_b;
  logic   out_valid;
  logic   out_ready;
  field_t ancestor;

  // Predictor state: 2^i-th ancestor rows and depths
  node_t  lift_table [NODES][LEVELS];
  depth_t node_depth [NODES];

  // Expected ancestors, oldest first
  field_t lca_expected [$];

  // Tree bookkeeping for stimulus shaping
  bit     placed [NODES];
  node_t  placed_list [$];
  node_t  last_node;
  int     chain_left;

  int     tx_idle_pct;
  int     rx_idle_pct;
  int     hold_reqs;
  int     err_cnt;
  int     cycle_cnt;

  lca_binary_lifting i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ancestor  (ancestor)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Field value to node index; out of range means the sentinel
  function automatic node_t clip_node(input field_t v);
    if (int'(v) < NODES) return node_t'(v);
    return '0;
  endfunction

  function automatic void tree_insert(input node_t n, input node_t p);
    int lv;
    if (n == '0) return;
    lift_table[n][0] = p;
    for (lv = 1; lv < LEVELS; lv++)
      lift_table[n][lv] = lift_table[lift_table[n][lv-1]][lv-1];
    if (p == '0) begin
      node_depth[n] = '0;
    end else if (node_depth[p] >= lcabl_pkg::DEPTH_MAX) begin
      node_depth[n] = lcabl_pkg::DEPTH_MAX;
    end else begin
      node_depth[n] = node_depth[p] + depth_t'(1);
    end
  endfunction

  function automatic node_t tree_lca(input node_t a, input node_t b);
    node_t  lo;
    node_t  hi;
    depth_t diff;
    int     lv;
    lo = a;
    hi = b;
    if (node_depth[lo] > node_depth[hi]) begin
      lo = b;
      hi = a;
    end
    // lift the deeper node by the depth difference
    diff = node_depth[hi] - node_depth[lo];
    for (lv = 0; lv < LEVELS; lv++)
      if (((diff >> lv) & 1) != 0) hi = lift_table[hi][lv];
    if (lo == hi) return lo;
    // climb both from the top level wherever they still differ
    for (lv = LEVELS - 1; lv >= 0; lv--) begin
      if (lift_table[lo][lv] != lift_table[hi][lv]) begin
        lo = lift_table[lo][lv];
        hi = lift_table[hi][lv];
      end
    end
    return lift_table[lo][0];
  endfunction

  function automatic void mark_placed(input node_t n);
    if (n != '0 && !placed[n]) begin
      placed[n] = 1'b1;
      placed_list = {placed_list, n};
    end
  endfunction

  function automatic node_t any_placed();
    if (placed_list.size() == 0) return node_t'($urandom_range(NODES - 1));
    return placed_list[$urandom_range(placed_list.size() - 1)];
  endfunction

  // Unused nonzero node if one turns up quickly, else a placed one
  function automatic node_t fresh_node();
    node_t c;
    int    k;
    for (k = 0; k < 16; k++) begin
      c = node_t'($urandom_range(1, NODES - 1));
      if (!placed[c]) return c;
    end
    return any_placed();
  endfunction

  // Offer one item, wait for acceptance, then update the predictor
  task automatic offer(input logic op, input field_t a, input field_t b,
                       input bit fixed, input field_t want);
    node_t  na;
    node_t  nb;
    field_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd      <= op;
    node_a   <= a;
    node_b   <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    na = clip_node(a);
    nb = clip_node(b);
    if (op == lcabl_pkg::CMD_INSERT) begin
      tree_insert(na, nb);
      if (na != '0) begin
        mark_placed(na);
        last_node = na;
      end
    end else begin
      res = field_t'(tree_lca(na, nb));
      lca_expected = {lca_expected, (fixed ? want : res)};
    end
    @(negedge clk);
  endtask

  // Mostly well-formed tree growth with queries; some loops and noise
  task automatic random_item(output bit counted);
    node_t n;
    node_t p;
    node_t x;
    node_t y;
    int    r;
    counted = 1'b1;
    r = $urandom_range(99);
    if (chain_left == 0 && r == 0) chain_left = $urandom_range(8, 80);
    if (chain_left > 0 || r < 40) begin
      n = fresh_node();
      if (chain_left > 0) begin
        // deep chain under the latest node
        chain_left--;
        p = last_node;
      end else begin
        case ($urandom_range(9))
          0, 1, 2:    p = last_node;
          3, 4, 5, 6: p = any_placed();
          7:          p = '0;
          default:    p = node_t'($urandom_range(NODES - 1));
        endcase
      end
      offer(lcabl_pkg::CMD_INSERT, n, p, 1'b0, '0);
    end else if (r < 47) begin
      // re-insert; a descendant or itself as parent makes a loop
      n = any_placed();
      case ($urandom_range(3))
        0, 1:    p = any_placed();
        2:       p = n;
        default: p = node_t'($urandom_range(NODES - 1));
      endcase
      offer(lcabl_pkg::CMD_INSERT, n, p, 1'b0, '0);
    end else if (r < 49) begin
      counted = 1'b0;
      offer(lcabl_pkg::CMD_INSERT, '0, field_t'($urandom_range(FIELD_MAX)), 1'b0, '0);
    end else if (r < 88) begin
      x = any_placed();
      case ($urandom_range(4))
        0, 1:    y = any_placed();
        2:       y = last_node;
        3:       y = x;
        default: y = '0;
      endcase
      offer(lcabl_pkg::CMD_QUERY, x, y, 1'b0, '0);
    end else begin
      offer(lcabl_pkg::CMD_QUERY, field_t'($urandom_range(FIELD_MAX)),
            field_t'($urandom_range(FIELD_MAX)), 1'b0, '0);
    end
  endtask

  // Sender side: reset, directed table, random items, depth saturation
  initial begin : stimulus
    int    i;
    int    j;
    int    step_no;
    int    rand_done;
    bit    counted;
    node_t sat;
    node_t kid;
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = lcabl_pkg::CMD_INSERT;
    node_a    = '0;
    node_b    = '0;
    hold_reqs = 0;
    last_node = '0;
    chain_left = 0;
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    for (i = 0; i < NODES; i++) begin
      node_depth[i] = '0;
      for (j = 0; j < LEVELS; j++) lift_table[i][j] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(DIRECTED); i++)
      offer(DIRECTED[i].cmd, DIRECTED[i].a, DIRECTED[i].b,
            DIRECTED[i].fixed, DIRECTED[i].want);

    step_no   = 0;
    rand_done = 0;
    while (rand_done < RANDOM_ITEMS) begin
      // receiver hold-off while items keep coming
      if (step_no == 80 || step_no == 380) hold_reqs++;
      if (step_no == 150) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (step_no == 300) begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      random_item(counted);
      if (counted) rand_done++;
      step_no++;
    end

    // self loop pushes the depth past its saturation point
    sat = any_placed();
    repeat (SAT_INSERTS) offer(lcabl_pkg::CMD_INSERT, sat, sat, 1'b0, '0);
    kid = fresh_node();
    offer(lcabl_pkg::CMD_INSERT, kid, sat, 1'b0, '0);
    offer(lcabl_pkg::CMD_QUERY, kid, sat, 1'b0, '0);
    offer(lcabl_pkg::CMD_QUERY, sat, sat, 1'b0, '0);
    repeat (20)
      offer(lcabl_pkg::CMD_QUERY, any_placed(),
            ($urandom_range(1) != 0) ? sat : kid, 1'b0, '0);
    in_valid <= 1'b0;

    while (lca_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && lca_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver side: random stalls, long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted ancestor item with the oldest expectation
  always @(posedge clk) begin : check_ancestor
    field_t want;
    if (!rst && out_valid && out_ready) begin
      if (lca_expected.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected ancestor item %0d at cycle %0d", ancestor, cycle_cnt);
      end else begin
        want = lca_expected.pop_front();
        if (ancestor !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("ancestor mismatch at cycle %0d: expected %0d, got %0d",
                     cycle_cnt, want, ancestor);
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    err_cnt   = 0;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
